[rtl/core/grid_cost_wavefront_spread_assert.svh]
// Assertion macros for the wavefront spread block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GRID_COST_WAVEFRONT_SPREAD_ASSERT_SVH
`define GRID_COST_WAVEFRONT_SPREAD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gcws_pkg.sv]
package gcws_pkg;

  // Operation codes of an input request.
  typedef enum logic [1:0] {
    OP_WRITE_COST  = 2'd0,
    OP_START_TIMER = 2'd1,
    OP_TICK        = 2'd2,
    OP_READ_CELL   = 2'd3
  } op_e;

  localparam int unsigned CoordW   = 6;
  localparam int unsigned CostW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned GridRegW = 7;
  localparam int unsigned CfgIdxW  = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT = 8'd1;

  localparam logic [GridRegW-1:0] GridDimReset = 7'd64;

  typedef struct packed {
    op_e               operation;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CostW-1:0]  cost_value;
    logic [TimeW-1:0]  time_value;
  } item_t;

  typedef struct packed {
    logic             did_spread;
    logic             cell_visited;
    logic             cell_active;
    logic [TimeW-1:0] cell_start_time;
    logic [TimeW-1:0] total_time;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_index;
    logic [GridRegW-1:0] reg_wdata;
  } cfg_t;

  // One word of the cell memory.
  typedef struct packed {
    logic             visited;
    logic             active;
    logic [TimeW-1:0] start;
  } cell_t;

  // Firing decision for the cell under the scan.
  typedef struct packed {
    logic             fire;
    logic [TimeW-1:0] fire_time;
  } fire_t;

  // Unsigned add that sticks at all ones.
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

endpackage

[rtl/core/gcws_chan_if.sv]
// Valid/ready channel carrying one payload word per request.
interface gcws_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/gcws_cell_alu.sv]
// Per-cell arithmetic: the firing test of the scanned cell and the update
// of a neighbour that is offered a new start time.
module gcws_cell_alu import gcws_pkg::*; (
  input  logic [TimeW-1:0] total_i,
  input  cell_t            cell_i,
  input  logic [CostW-1:0] cost_i,
  input  logic [TimeW-1:0] offer_time_i,
  output fire_t            fire_o,
  output cell_t            fired_cell_o,
  output cell_t            offered_cell_o
);

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] cost_ext;

  assign cost_ext = TimeW'(cost_i);
  assign elapsed  = total_i - cell_i.start;

  // A cell fires once the time since its start exceeds its cost.
  assign fire_o.fire      = cell_i.active && (total_i >= cell_i.start) && (elapsed > cost_ext);
  assign fire_o.fire_time = sat_add(cell_i.start, cost_ext);

  // A fired cell becomes visited and stops its timer; the start time is kept.
  always_comb begin
    fired_cell_o         = cell_i;
    fired_cell_o.visited = 1'b1;
    fired_cell_o.active  = 1'b0;
  end

  // An unvisited neighbour is started, or lowered to the earlier time.
  always_comb begin
    offered_cell_o = cell_i;
    if (!cell_i.visited) begin
      if (!cell_i.active || (offer_time_i < cell_i.start)) begin
        offered_cell_o.active = 1'b1;
        offered_cell_o.start  = offer_time_i;
      end
    end
  end

endmodule

[rtl/core/grid_cost_wavefront_spread.sv]
// Wavefront spread over a grid of up to MAX_WIDTH x MAX_HEIGHT cells. Each
// request writes a cell cost, starts a cell timer, reads a cell, or ticks,
// and yields exactly one result carrying the accumulated time. Per-cell state
// lives in two memories with a registered read (flags plus start time, and cost)
// that are worked by read-modify-write; one request is in progress at a time,
// but a new request is taken while the previous result waits at the output.
// A tick scans every cell of the W x H grid in use in row-major order and,
// for each firing cell, updates each of its in-grid neighbours; the cell
// memory has a single read and a single write per cycle. After reset every
// word of the cell memory (MAX_WIDTH*MAX_HEIGHT, 4096 by default) is cleared,
// during which no request is taken; configuration writes are taken always.
`include "grid_cost_wavefront_spread_assert.svh"

module grid_cost_wavefront_spread import gcws_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcws_chan_if.sink    item_i,
  gcws_chan_if.source  result_o,
  gcws_chan_if.sink    cfg_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WDW   =
      ($clog2(MAX_WIDTH + 1) > GridRegW) ? $clog2(MAX_WIDTH + 1) : GridRegW;
  localparam int unsigned HDW   =
      ($clog2(MAX_HEIGHT + 1) > GridRegW) ? $clog2(MAX_HEIGHT + 1) : GridRegW;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START_WR,
    ST_READ_EV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_NB_SEL,
    ST_NB_EV,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    NB_LEFT,
    NB_RIGHT,
    NB_UP,
    NB_DOWN
  } nb_e;

  state_e               state_q;
  nb_e                  nb_q;
  logic [AW-1:0]        clr_addr_q;
  logic [XW-1:0]        x_q;
  logic [YW-1:0]        y_q;
  logic [GridRegW-1:0]  grid_w_q;
  logic [GridRegW-1:0]  grid_h_q;
  logic [TimeW-1:0]     total_q;
  logic                 fired_any_q;
  logic [TimeW-1:0]     fire_time_q;
  op_e                  op_q;
  logic [TimeW-1:0]     time_q;
  logic [AW-1:0]        addr_q;
  logic                 in_grid_q;
  logic                 rd_visited_q;
  logic                 rd_active_q;
  logic [TimeW-1:0]     rd_start_q;
  logic                 out_valid_q;
  result_t              out_q;

  // Memories and their ports.
  cell_t                cell_mem [Depth];
  logic [CostW-1:0]     cost_mem [Depth];
  cell_t                cell_rdata_q;
  logic [CostW-1:0]     cost_rdata_q;
  logic                 cell_re;
  logic [AW-1:0]        cell_raddr;
  logic                 cell_we;
  logic [AW-1:0]        cell_waddr;
  cell_t                cell_wdata;
  logic                 cost_re;
  logic                 cost_we;
  logic [AW-1:0]        cost_addr;

  logic [WDW-1:0]       used_w;
  logic [HDW-1:0]       used_h;
  logic                 in_grid;
  logic [AW-1:0]        addr_in;
  logic [AW-1:0]        scan_addr;
  logic [AW-1:0]        nb_addr;
  logic [XW-1:0]        nb_x;
  logic [YW-1:0]        nb_y;
  logic                 nb_ok;
  logic                 last_x;
  logic                 last_y;
  logic                 advance;
  logic                 item_fire;
  fire_t                fire;
  cell_t                fired_cell;
  cell_t                offered_cell;

  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] yv,
                                              input logic [XW-1:0] xv);
    return AW'(32'(yv) * MAX_WIDTH + 32'(xv));
  endfunction

  // Grid in use, clamped to the storage size.
  assign used_w = (WDW'(grid_w_q) > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : WDW'(grid_w_q);
  assign used_h = (HDW'(grid_h_q) > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : HDW'(grid_h_q);

  // Addressed cell of an incoming request.
  assign in_grid = (WDW'(item_i.data.cell_x) < used_w) && (HDW'(item_i.data.cell_y) < used_h);
  assign addr_in = cell_addr(YW'(item_i.data.cell_y), XW'(item_i.data.cell_x));

  // Scan position and its neighbours.
  assign scan_addr = cell_addr(y_q, x_q);
  assign last_x    = (WDW'(x_q) + WDW'(1)) == used_w;
  assign last_y    = (HDW'(y_q) + HDW'(1)) == used_h;

  always_comb begin
    nb_x  = x_q;
    nb_y  = y_q;
    nb_ok = 1'b0;
    unique case (nb_q)
      NB_LEFT: begin
        nb_x  = x_q - 1'b1;
        nb_ok = (x_q != '0);
      end
      NB_RIGHT: begin
        nb_x  = x_q + 1'b1;
        nb_ok = !last_x;
      end
      NB_UP: begin
        nb_y  = y_q - 1'b1;
        nb_ok = (y_q != '0);
      end
      NB_DOWN: begin
        nb_y  = y_q + 1'b1;
        nb_ok = !last_y;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr = cell_addr(nb_y, nb_x);

  gcws_cell_alu u_alu (
    .total_i        (total_q),
    .cell_i         (cell_rdata_q),
    .cost_i         (cost_rdata_q),
    .offer_time_i   (fire_time_q),
    .fire_o         (fire),
    .fired_cell_o   (fired_cell),
    .offered_cell_o (offered_cell)
  );

  // Handshakes.
  assign item_i.ready   = (state_q == ST_IDLE);
  assign item_fire      = item_i.valid && item_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // The scan moves on once the current cell and its neighbours are done.
  assign advance = ((state_q == ST_SCAN_EV) && !fire.fire) ||
                   ((state_q == ST_NB_SEL) && !nb_ok && (nb_q == NB_DOWN)) ||
                   ((state_q == ST_NB_EV) && (nb_q == NB_DOWN));

  // Memory port control.
  always_comb begin
    cell_re    = 1'b0;
    cell_raddr = scan_addr;
    cell_we    = 1'b0;
    cell_waddr = scan_addr;
    cell_wdata = fired_cell;
    cost_re    = 1'b0;
    cost_we    = 1'b0;
    cost_addr  = scan_addr;
    unique case (state_q)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr_q;
        cell_wdata = '0;
      end
      ST_IDLE: begin
        if (item_fire) begin
          cell_raddr = addr_in;
          cost_addr  = addr_in;
          cell_re    = (item_i.data.operation == OP_START_TIMER) ||
                       (item_i.data.operation == OP_READ_CELL);
          cost_we    = (item_i.data.operation == OP_WRITE_COST) && in_grid;
        end
      end
      ST_START_WR: begin
        cell_we          = in_grid_q;
        cell_waddr       = addr_q;
        cell_wdata       = cell_rdata_q;
        cell_wdata.active = 1'b1;
        cell_wdata.start = time_q;
      end
      ST_SCAN_RD: begin
        cell_re = 1'b1;
        cost_re = 1'b1;
      end
      ST_SCAN_EV: begin
        cell_we = fire.fire;
      end
      ST_NB_SEL: begin
        cell_re    = nb_ok;
        cell_raddr = nb_addr;
      end
      ST_NB_EV: begin
        cell_we    = 1'b1;
        cell_waddr = nb_addr;
        cell_wdata = offered_cell;
      end
      default: begin
        cell_re = 1'b0;
      end
    endcase
  end

  // Cell memory: visited and active flags with the timer start time.
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  // Cost memory.
  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_addr] <= item_i.data.cost_value;
    end
    if (cost_re) begin
      cost_rdata_q <= cost_mem[cost_addr];
    end
  end

  // Sequencer with its counters, configuration and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      nb_q         <= NB_LEFT;
      clr_addr_q   <= '0;
      x_q          <= '0;
      y_q          <= '0;
      grid_w_q     <= GridDimReset;
      grid_h_q     <= GridDimReset;
      total_q      <= '0;
      fired_any_q  <= 1'b0;
      fire_time_q  <= '0;
      op_q         <= OP_WRITE_COST;
      time_q       <= '0;
      addr_q       <= '0;
      in_grid_q    <= 1'b0;
      rd_visited_q <= 1'b0;
      rd_active_q  <= 1'b0;
      rd_start_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // Configuration writes; unknown indexes are dropped.
      if (cfg_i.valid) begin
        if (cfg_i.data.reg_index == CFG_GRID_WIDTH) begin
          grid_w_q <= cfg_i.data.reg_wdata;
        end else if (cfg_i.data.reg_index == CFG_GRID_HEIGHT) begin
          grid_h_q <= cfg_i.data.reg_wdata;
        end
      end

      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_fire) begin
            op_q         <= item_i.data.operation;
            time_q       <= item_i.data.time_value;
            addr_q       <= addr_in;
            in_grid_q    <= in_grid;
            fired_any_q  <= 1'b0;
            rd_visited_q <= 1'b0;
            rd_active_q  <= 1'b0;
            rd_start_q   <= '0;
            unique case (item_i.data.operation)
              OP_WRITE_COST:  state_q <= ST_RESP;
              OP_START_TIMER: state_q <= ST_START_WR;
              OP_READ_CELL:   state_q <= ST_READ_EV;
              OP_TICK: begin
                total_q <= sat_add(total_q, item_i.data.time_value);
                x_q     <= '0;
                y_q     <= '0;
                state_q <= ((used_w == '0) || (used_h == '0)) ? ST_RESP : ST_SCAN_RD;
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_START_WR: begin
          state_q <= ST_RESP;
        end
        ST_READ_EV: begin
          if (in_grid_q) begin
            rd_visited_q <= cell_rdata_q.visited;
            rd_active_q  <= cell_rdata_q.active;
            rd_start_q   <= cell_rdata_q.start;
          end
          state_q <= ST_RESP;
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (fire.fire) begin
            fired_any_q <= 1'b1;
            fire_time_q <= fire.fire_time;
            nb_q        <= NB_LEFT;
            state_q     <= ST_NB_SEL;
          end
        end
        ST_NB_SEL: begin
          if (nb_ok) begin
            state_q <= ST_NB_EV;
          end else if (nb_q != NB_DOWN) begin
            nb_q <= nb_e'(nb_q + 2'd1);
          end
        end
        ST_NB_EV: begin
          if (nb_q != NB_DOWN) begin
            nb_q    <= nb_e'(nb_q + 2'd1);
            state_q <= ST_NB_SEL;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q           <= 1'b1;
            out_q.did_spread      <= (op_q == OP_TICK) && fired_any_q;
            out_q.cell_visited    <= rd_visited_q;
            out_q.cell_active     <= rd_active_q;
            out_q.cell_start_time <= rd_start_q;
            out_q.total_time      <= total_q;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Step to the next cell in row-major order, or finish the tick.
      if (advance) begin
        if (last_x && last_y) begin
          state_q <= ST_RESP;
        end else begin
          state_q <= ST_SCAN_RD;
          if (last_x) begin
            x_q <= '0;
            y_q <= y_q + 1'b1;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
      end
    end
  end

  // A firing cell is written back as visited and inactive.
  `GCWS_ASSERT_SAME(a_fire_writes_back, (state_q == ST_SCAN_EV) && fire.fire, cell_we && cell_wdata.visited && !cell_wdata.active && (cell_waddr == scan_addr), "fired cell not written back")

  // Accumulated time never goes backwards.
  `GCWS_ASSERT_NEXT(a_total_monotonic, 1'b1, total_q >= $past(total_q), "accumulated time decreased")

  // Only one request is in progress at a time.
  `GCWS_ASSERT_NEXT(a_one_in_flight, item_fire, !item_i.ready, "request taken while busy")

endmodule

[tb/grid_cost_wavefront_spread_test.sv]
`timescale 1ns / 1ps

module grid_cost_wavefront_spread_test;
  import gcws_pkg::*;

  localparam int unsigned ColMax    = 64;
  localparam int unsigned RowMax    = 64;
  localparam int unsigned CellCount = ColMax * RowMax;

  // Register indexes that the block does not decode.
  localparam logic [CfgIdxW-1:0] CfgUnknownNext = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgUnknownTop  = 8'hFF;

  logic clk_i;
  logic rst_ni;

  gcws_chan_if #(.payload_t(item_t))   item_ch ();
  gcws_chan_if #(.payload_t(result_t)) result_ch ();
  gcws_chan_if #(.payload_t(cfg_t))    cfg_ch ();

  grid_cost_wavefront_spread uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // Shadow copy of the grid, the accumulated time and the size registers.
  logic [CostW-1:0]    cost_mem [CellCount];
  bit                  visited_mem [CellCount];
  bit                  active_mem [CellCount];
  logic [TimeW-1:0]    start_mem [CellCount];
  bit                  cost_known [CellCount];
  bit                  start_known [CellCount];
  logic [TimeW-1:0]    clock_total = '0;
  logic [GridRegW-1:0] cols_reg = GridDimReset;
  logic [GridRegW-1:0] rows_reg = GridDimReset;

  result_t pending_results [$];
  bit      failed = 1'b0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      holding = 1'b0;
  event    stall_receiver;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned cols_used();
    return (cols_reg > ColMax) ? ColMax : int'(cols_reg);
  endfunction

  function automatic int unsigned rows_used();
    return (rows_reg > RowMax) ? RowMax : int'(rows_reg);
  endfunction

  function automatic logic [TimeW-1:0] time_add(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    logic [TimeW-1:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  // A firing cell hands its finish time on to an unvisited neighbour.
  function automatic void offer_start(input int x, input int y,
                                      input logic [TimeW-1:0] t);
    int unsigned slot;
    if (x < 0 || y < 0 || x >= int'(cols_used()) || y >= int'(rows_used())) return;
    slot = y * ColMax + x;
    if (visited_mem[slot]) return;
    if (!active_mem[slot]) begin
      active_mem[slot]  = 1'b1;
      start_mem[slot]   = t;
      start_known[slot] = 1'b1;
    end else if (t < start_mem[slot]) begin
      start_mem[slot] = t;
    end
  endfunction

  // One tick: advance the clock, then sweep the grid in row-major order.
  function automatic bit scan_grid(input logic [TimeW-1:0] dt);
    int unsigned      slot;
    logic [TimeW-1:0] began;
    logic [TimeW-1:0] reach;
    bit               any_fired;
    any_fired   = 1'b0;
    clock_total = time_add(clock_total, dt);
    for (int y = 0; y < int'(rows_used()); y++) begin
      for (int x = 0; x < int'(cols_used()); x++) begin
        slot = y * ColMax + x;
        if (!active_mem[slot]) continue;
        began = start_mem[slot];
        if (clock_total < began || clock_total - began <= TimeW'(cost_mem[slot])) continue;
        active_mem[slot]  = 1'b0;
        visited_mem[slot] = 1'b1;
        reach = time_add(began, TimeW'(cost_mem[slot]));
        offer_start(x - 1, y, reach);
        offer_start(x + 1, y, reach);
        offer_start(x, y - 1, reach);
        offer_start(x, y + 1, reach);
        any_fired = 1'b1;
      end
    end
    return any_fired;
  endfunction

  // Expected result of one request; the shadow state moves on with it.
  function automatic result_t predict_result(input item_t it);
    result_t     res;
    bit          in_grid;
    int unsigned slot;
    res     = '0;
    in_grid = it.cell_x < cols_used() && it.cell_y < rows_used();
    slot    = int'(it.cell_y) * ColMax + int'(it.cell_x);
    case (it.operation)
      OP_WRITE_COST: begin
        if (in_grid) begin
          cost_mem[slot]   = it.cost_value;
          cost_known[slot] = 1'b1;
        end
      end
      OP_START_TIMER: begin
        if (in_grid) begin
          active_mem[slot]  = 1'b1;
          start_mem[slot]   = it.time_value;
          start_known[slot] = 1'b1;
        end
      end
      OP_TICK: begin
        res.did_spread = scan_grid(it.time_value);
      end
      OP_READ_CELL: begin
        if (in_grid) begin
          res.cell_visited    = visited_mem[slot];
          res.cell_active     = active_mem[slot];
          res.cell_start_time = start_mem[slot];
        end
      end
      default: ;
    endcase
    res.total_time = clock_total;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [TimeW-1:0] want,
                                      input logic [TimeW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      failed = 1'b1;
    end
  endfunction

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, result_ch.data);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("did_spread", TimeW'(want.did_spread), TimeW'(result_ch.data.did_spread));
        check_field("cell_visited", TimeW'(want.cell_visited),
                    TimeW'(result_ch.data.cell_visited));
        check_field("cell_active", TimeW'(want.cell_active),
                    TimeW'(result_ch.data.cell_active));
        check_field("cell_start_time", want.cell_start_time, result_ch.data.cell_start_time);
        check_field("total_time", want.total_time, result_ch.data.total_time);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for.
  always @(negedge clk_i) begin
    result_ch.ready = holding ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    @(stall_receiver);
    holding = 1'b1;
    repeat (300) @(negedge clk_i);
    holding = 1'b0;
  end

  initial begin
    #(64'd20_000_000);
    $display("grid_cost_wavefront_spread verification failed");
    $finish;
  end

  // Every task below starts and ends just after a falling edge.
  task automatic send_request(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid = 1'b1;
    item_ch.data  = it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    pending_results.push_back(predict_result(it));
    @(negedge clk_i);
  endtask

  task automatic send_op(input op_e op, input int x, input int y,
                         input logic [CostW-1:0] cost, input logic [TimeW-1:0] tv);
    item_t it;
    it.operation  = op;
    it.cell_x     = x[CoordW-1:0];
    it.cell_y     = y[CoordW-1:0];
    it.cost_value = cost;
    it.time_value = tv;
    send_request(it);
  endtask

  task automatic drain();
    item_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Size registers are written only once every result is back.
  task automatic write_grid_register(input logic [CfgIdxW-1:0] idx,
                                     input logic [GridRegW-1:0] value);
    drain();
    cfg_ch.valid          = 1'b1;
    cfg_ch.data.reg_index = idx;
    cfg_ch.data.reg_wdata = value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == CFG_GRID_WIDTH) cols_reg = value;
    else if (idx == CFG_GRID_HEIGHT) rows_reg = value;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [CostW-1:0] random_cost();
    if ($urandom_range(0, 15) == 0) return CostW'($urandom());
    return CostW'($urandom_range(0, 'h280));
  endfunction

  // Costs of every cell in use are written before any timer can reach it.
  task automatic set_grid(input logic [GridRegW-1:0] w, input logic [GridRegW-1:0] h);
    write_grid_register(CFG_GRID_WIDTH, w);
    write_grid_register(CFG_GRID_HEIGHT, h);
    for (int y = 0; y < int'(rows_used()); y++)
      for (int x = 0; x < int'(cols_used()); x++)
        if (!cost_known[y * ColMax + x])
          send_op(OP_WRITE_COST, x, y, random_cost(), $urandom());
  endtask

  function automatic int pick_col();
    if (cols_used() == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, cols_used() - 1);
  endfunction

  function automatic int pick_row();
    if (rows_used() == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, rows_used() - 1);
  endfunction

  // A cell in use may be read only once its start time has been set.
  function automatic bit readable(input int x, input int y);
    return x >= int'(cols_used()) || y >= int'(rows_used()) || start_known[y * ColMax + x];
  endfunction

  function automatic logic [TimeW-1:0] random_start();
    int unsigned r;
    int unsigned back;
    r    = $urandom_range(0, 9);
    back = $urandom_range(0, 'h300);
    if (r == 0) return $urandom();
    if (r == 1) return time_add(clock_total, $urandom_range(1, 'h200));
    return (clock_total > back) ? clock_total - back : '0;
  endfunction

  function automatic logic [TimeW-1:0] random_step();
    if ($urandom_range(0, 9) == 0) return '0;
    return $urandom_range(1, 'h300);
  endfunction

  task automatic random_request();
    int r;
    int x;
    int y;
    int tries;
    r     = $urandom_range(0, 99);
    x     = pick_col();
    y     = pick_row();
    tries = 0;
    if (r < 15) begin
      send_op(OP_WRITE_COST, x, y, random_cost(), $urandom());
    end else if (r < 35) begin
      send_op(OP_START_TIMER, x, y, $urandom(), random_start());
    end else if (r < 70) begin
      send_op(OP_TICK, x, y, $urandom(), random_step());
    end else begin
      while (!readable(x, y) && tries < 20) begin
        x = pick_col();
        y = pick_row();
        tries++;
      end
      if (readable(x, y)) send_op(OP_READ_CELL, x, y, $urandom(), $urandom());
      else send_op(OP_TICK, x, y, $urandom(), random_step());
    end
  endtask

  // A single wavefront on a small grid: exact threshold, zero and full
  // costs, lowering of a later start, restart of a visited cell and a start
  // in the future.
  task automatic test_first_wavefront();
    set_grid(7'd4, 7'd3);
    send_op(OP_WRITE_COST, 0, 0, 16'h0100, $urandom());
    send_op(OP_WRITE_COST, 1, 0, 16'h0000, $urandom());
    send_op(OP_WRITE_COST, 2, 0, 16'hFFFF, $urandom());
    send_op(OP_WRITE_COST, 63, 63, $urandom(), $urandom());
    send_op(OP_WRITE_COST, 1, 1, 16'h0800, $urandom());
    send_op(OP_START_TIMER, 0, 0, $urandom(), clock_total);
    send_op(OP_START_TIMER, 1, 1, $urandom(), clock_total + 32'h0F00);
    send_op(OP_READ_CELL, 0, 0, $urandom(), $urandom());
    send_op(OP_READ_CELL, 63, 63, $urandom(), $urandom());
    send_op(OP_TICK, 0, 0, $urandom(), 32'h0);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h0100);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h0001);
    send_op(OP_READ_CELL, 1, 0, $urandom(), $urandom());
    send_op(OP_READ_CELL, 1, 1, $urandom(), $urandom());
    send_op(OP_READ_CELL, 2, 0, $urandom(), $urandom());
    send_op(OP_START_TIMER, 1, 0, $urandom(), 32'h0050);
    send_op(OP_READ_CELL, 1, 0, $urandom(), $urandom());
    send_op(OP_START_TIMER, 3, 2, $urandom(), 32'hFFFF_FF00);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h0200);
    send_op(OP_READ_CELL, 3, 2, $urandom(), $urandom());
  endtask

  // Empty grids, sizes above the maximum, single rows and columns, and
  // writes to indexes that the block does not decode.
  task automatic test_grid_limits();
    set_grid(7'd0, 7'd3);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h10);
    send_op(OP_READ_CELL, 0, 0, $urandom(), $urandom());
    send_op(OP_START_TIMER, 0, 0, $urandom(), clock_total);
    send_op(OP_WRITE_COST, 0, 0, $urandom(), $urandom());
    set_grid(7'd127, 7'd1);
    send_op(OP_START_TIMER, 63, 0, $urandom(), clock_total - 32'h40);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h80);
    send_op(OP_READ_CELL, 63, 0, $urandom(), $urandom());
    send_op(OP_READ_CELL, 10, 1, $urandom(), $urandom());
    write_grid_register(CfgUnknownNext, 7'h7F);
    write_grid_register(CfgUnknownTop, 7'h00);
    send_op(OP_READ_CELL, 63, 0, $urandom(), $urandom());
    set_grid(7'd1, 7'd0);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h20);
    set_grid(7'd1, 7'd127);
    send_op(OP_START_TIMER, 0, 63, $urandom(), clock_total);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h100);
    send_op(OP_READ_CELL, 0, 63, $urandom(), $urandom());
    send_op(OP_READ_CELL, 1, 0, $urandom(), $urandom());
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    -> stall_receiver;
    repeat (8) begin
      send_op(OP_READ_CELL, 0, 63, $urandom(), $urandom());
      send_op(OP_WRITE_COST, 0, $urandom_range(0, 63), random_cost(), $urandom());
    end
    send_idle_pct = saved_pct;
  endtask

  // Random requests over a spread of mostly small grid sizes.
  task automatic test_random_mix(input int count);
    int done;
    int r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 9);
      if (r == 0) set_grid(7'd64, GridRegW'($urandom_range(1, 2)));
      else if (r == 1) set_grid(7'd1, 7'd64);
      else if (r == 2) set_grid(GridRegW'($urandom_range(65, 127)), 7'd1);
      else set_grid(GridRegW'($urandom_range(1, 10)), GridRegW'($urandom_range(1, 10)));
      repeat ($urandom_range(6, 14)) begin
        random_request();
        done++;
      end
    end
  endtask

  // A few requests on the whole grid, with fronts from opposite corners.
  task automatic test_full_grid();
    set_grid(7'd64, 7'd64);
    send_op(OP_START_TIMER, 0, 0, $urandom(), clock_total);
    send_op(OP_START_TIMER, 63, 63, $urandom(), clock_total);
    repeat (10) random_request();
  endtask

  // The accumulated time sticks at its top value.
  task automatic test_time_saturation();
    set_grid(7'd3, 7'd3);
    send_op(OP_START_TIMER, 1, 1, $urandom(), clock_total);
    send_op(OP_TICK, 0, 0, $urandom(), 32'hFFFF_FFFF);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h10);
    send_op(OP_START_TIMER, 2, 2, $urandom(), 32'hFFFF_FFFF);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h0);
    send_op(OP_READ_CELL, 2, 2, $urandom(), $urandom());
    send_op(OP_WRITE_COST, 0, 0, 16'h0010, $urandom());
    send_op(OP_START_TIMER, 0, 0, $urandom(), 32'hFFFF_FF00);
    send_op(OP_TICK, 0, 0, $urandom(), 32'h1);
    send_op(OP_READ_CELL, 0, 0, $urandom(), $urandom());
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  initial begin
    rst_ni          = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    set_idle(35, 80);
    test_first_wavefront();
    test_grid_limits();
    test_backpressure();
    test_random_mix(35);
    set_idle(80, 35);
    test_random_mix(35);
    set_idle(0, 0);
    test_random_mix(30);
    test_full_grid();
    test_time_saturation();

    drain();
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("grid_cost_wavefront_spread verification clean");
    end else begin
      $display("grid_cost_wavefront_spread verification failed");
    end
    $finish;
  end

endmodule

[grid_cost_wavefront_spread.f]
+incdir+rtl/core
rtl/core/gcws_pkg.sv
rtl/core/gcws_chan_if.sv
rtl/core/gcws_cell_alu.sv
rtl/core/grid_cost_wavefront_spread.sv
tb/grid_cost_wavefront_spread_test.sv
